### rtl/hwr_pkg.sv
// ----------------------------------------------------------------------------
// hwr_pkg: shared definitions for the hue wheel to RGB block
// Field widths, register map, sextant codes and the color lookup function.
// ----------------------------------------------------------------------------
package hwr_pkg;

  // Field widths.
  localparam int HUE_W   = 16;
  localparam int SEG_W   = 14;  // Segment length is at most 65535 / 6 = 10922.
  localparam int LEVEL_W = 8;
  localparam int SEXT_W  = 3;

  // Wheel constants.
  localparam int                 NUM_SEGMENTS     = 6;
  localparam logic [LEVEL_W-1:0] FULL_LEVEL       = 8'hFF;
  localparam logic [HUE_W-1:0]   HUE_PERIOD_RESET = 16'd360;
  localparam logic [SEG_W-1:0]   SEG_RESET        = SEG_W'(360 / NUM_SEGMENTS);

  // Divide by six as a multiply by a reciprocal: floor(x * 43691 / 2^18) is
  // exact for every 16-bit x.
  localparam logic [HUE_W-1:0] SEG_RECIP   = 16'hAAAB;
  localparam int               RECIP_SHIFT = 18;

  // Configuration port.
  localparam int                  APB_ADDR_W     = 2;
  localparam int                  APB_DATA_W     = 32;
  localparam logic [APB_ADDR_W-1:0] REG_HUE_PERIOD = 2'd0;

  // Sextants of the wheel, in order.
  typedef enum logic [SEXT_W-1:0] {
    SEXT_RED     = 3'd0,
    SEXT_YELLOW  = 3'd1,
    SEXT_GREEN   = 3'd2,
    SEXT_CYAN    = 3'd3,
    SEXT_BLUE    = 3'd4,
    SEXT_MAGENTA = 3'd5
  } sextant_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } rgb_t;

  // Build the color from the sextant and the rising ramp. An error gives black.
  function automatic rgb_t hwr_color(logic [SEXT_W-1:0] sext, logic err,
                                     logic [LEVEL_W-1:0] t);
    rgb_t               c;
    logic [LEVEL_W-1:0] q;
    q = FULL_LEVEL - t;
    c = '0;
    if (!err) begin
      case (sext)
        SEXT_RED:     begin c.red = FULL_LEVEL; c.green = t; end
        SEXT_YELLOW:  begin c.red = q; c.green = FULL_LEVEL; end
        SEXT_GREEN:   begin c.green = FULL_LEVEL; c.blue = t; end
        SEXT_CYAN:    begin c.green = q; c.blue = FULL_LEVEL; end
        SEXT_BLUE:    begin c.red = t; c.blue = FULL_LEVEL; end
        SEXT_MAGENTA: begin c.red = FULL_LEVEL; c.blue = q; end
        default:      c = '0;
      endcase
    end
    return c;
  endfunction

endpackage

### rtl/hwr_in_if.sv
// ----------------------------------------------------------------------------
// hwr_in_if: hue request channel
// Valid/ready channel that carries one hue position per request.
// ----------------------------------------------------------------------------
interface hwr_in_if import hwr_pkg::*;;
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue_value;

  modport source (output valid, output hue_value, input ready);
  modport sink   (input valid, input hue_value, output ready);
endinterface

### rtl/hwr_out_if.sv
// ----------------------------------------------------------------------------
// hwr_out_if: color result channel
// Valid/ready channel that carries one RGB color and its error flag.
// ----------------------------------------------------------------------------
interface hwr_out_if import hwr_pkg::*;;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] red;
  logic [LEVEL_W-1:0] green;
  logic [LEVEL_W-1:0] blue;
  logic               out_of_range;

  modport source (output valid, output red, output green, output blue,
                  output out_of_range, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input out_of_range, output ready);
endinterface

### rtl/hwr_cfg.sv
// ----------------------------------------------------------------------------
// hwr_cfg: configuration register file
// Holds the hue period and the derived segment length (period / 6).
// ----------------------------------------------------------------------------
module hwr_cfg import hwr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [SEG_W-1:0]      seg
);

  logic [HUE_W-1:0]   hue_period;
  logic               wr_hit;
  logic [2*HUE_W-1:0] seg_prod;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr == REG_HUE_PERIOD);

  // The segment length is taken from the written value at the same edge.
  assign seg_prod = pwdata[HUE_W-1:0] * SEG_RECIP;

  // Register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      hue_period <= HUE_PERIOD_RESET;
      seg        <= SEG_RESET;
    end else if (wr_hit) begin
      hue_period <= pwdata[HUE_W-1:0];
      seg        <= seg_prod[RECIP_SHIFT +: SEG_W];
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    if (paddr == REG_HUE_PERIOD) begin
      prdata = {{(APB_DATA_W-HUE_W){1'b0}}, hue_period};
    end
  end

endmodule

### rtl/hwr_div_cell.sv
// ----------------------------------------------------------------------------
// hwr_div_cell: one step of a restoring division chain
// Each cell produces one quotient bit and passes its partial remainder on.
// ----------------------------------------------------------------------------
module hwr_div_cell import hwr_pkg::*; #(
  parameter int RW = SEG_W,  // Remainder and divisor width.
  parameter int NW = HUE_W,  // Width of the combined dividend/quotient word.
  parameter int TW = 1       // Width of the tag carried alongside.
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [RW-1:0] in_rem,
  input  logic [NW-1:0] in_nq,
  input  logic [TW-1:0] in_tag,
  input  logic [RW-1:0] seg,
  input  logic          down_ld,
  output logic          ld,
  output logic          out_valid,
  output logic [RW-1:0] out_rem,
  output logic [NW-1:0] out_nq,
  output logic [TW-1:0] out_tag
);

  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          ge;
  logic [RW-1:0] rem_next;
  logic [NW-1:0] nq_next;

  // The cell takes a new request when it is empty or its neighbor moves on.
  assign ld = !out_valid || down_ld;

  // Shift the next dividend bit into the remainder and try to subtract.
  always_comb begin
    trial    = {in_rem, in_nq[NW-1]};
    diff     = trial - {1'b0, seg};
    ge       = trial >= {1'b0, seg};
    rem_next = ge ? diff[RW-1:0] : trial[RW-1:0];
    nq_next  = {in_nq[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_rem <= rem_next;
      out_nq  <= nq_next;
      out_tag <= in_tag;
    end
  end

endmodule

### rtl/hue_wheel_to_rgb.sv
// ----------------------------------------------------------------------------
// hue_wheel_to_rgb: hue position to fully saturated RGB color
// Two chains of division cells find the sextant, the remainder and the ramp.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+-----------------------------------------
//  hue_in   | in  | valid / ready   | hue_value[15:0]
//  rgb_out  | out | valid / ready   | red[7:0] green[7:0] blue[7:0] out_of_range
//  apb      | in  | psel / penable  | paddr[1:0] pwdata[31:0] prdata[31:0]
//
// One request is accepted every cycle while the output is not stalled; each
// result passes through 16 cells for the hue divide, one ramp setup stage,
// 8 cells for the ramp divide and the output register. A stalled output fills
// the empty cells first, so requests keep flowing until the whole chain is full.
// Reset clears all valid flags and restores the period to 360.
// ----------------------------------------------------------------------------
module hue_wheel_to_rgb import hwr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  hwr_in_if.sink                hue_in,
  hwr_out_if.source             rgb_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int N1   = HUE_W;    // Cells in the hue divide chain.
  localparam int N2   = LEVEL_W;  // Cells in the ramp divide chain.
  localparam int TAG2 = SEXT_W + 1;
  localparam int PRODW = SEG_W + LEVEL_W;

  logic [SEG_W-1:0] seg;

  // Hue divide chain signals; index 0 is the chain input.
  logic             c1_vld [0:N1];
  logic [SEG_W-1:0] c1_rem [0:N1];
  logic [HUE_W-1:0] c1_nq  [0:N1];
  logic             c1_tag [0:N1];
  logic             c1_ld  [0:N1];

  // Ramp divide chain signals.
  logic             c2_vld [0:N2];
  logic [SEG_W-1:0] c2_rem [0:N2];
  logic [N2-1:0]    c2_nq  [0:N2];
  logic [TAG2-1:0]  c2_tag [0:N2];
  logic             c2_ld  [0:N2];

  // Ramp setup stage.
  logic               mid_vld;
  logic [PRODW-1:0]   mid_n;
  logic [SEXT_W-1:0]  mid_sext;
  logic               mid_err;
  logic               mid_ld;
  logic [HUE_W-1:0]   h;
  logic [SEG_W-1:0]   f;
  logic               h_err;

  // Output stage.
  logic               out_ld;
  rgb_t               color;
  logic [SEXT_W-1:0]  fin_sext;
  logic               fin_err;

  // Configuration registers.
  hwr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .seg     (seg)
  );

  // Hue divide: quotient is the sextant, remainder the position inside it.
  // A zero segment length is flagged on entry.
  assign c1_vld[0]    = hue_in.valid;
  assign c1_rem[0]    = '0;
  assign c1_nq[0]     = hue_in.hue_value;
  assign c1_tag[0]    = (seg == '0);
  assign hue_in.ready = c1_ld[0];
  assign c1_ld[N1]    = mid_ld;

  for (genvar k = 0; k < N1; k++) begin : g_c1
    hwr_div_cell #(.RW(SEG_W), .NW(HUE_W), .TW(1)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c1_vld[k]),
      .in_rem    (c1_rem[k]),
      .in_nq     (c1_nq[k]),
      .in_tag    (c1_tag[k]),
      .seg       (seg),
      .down_ld   (c1_ld[k+1]),
      .ld        (c1_ld[k]),
      .out_valid (c1_vld[k+1]),
      .out_rem   (c1_rem[k+1]),
      .out_nq    (c1_nq[k+1]),
      .out_tag   (c1_tag[k+1])
    );
  end

  // Ramp setup: scale the remainder by 255 and check the sextant.
  assign h      = c1_nq[N1];
  assign f      = c1_rem[N1];
  assign h_err  = c1_tag[N1] || (h > HUE_W'(NUM_SEGMENTS - 1));
  assign mid_ld = !mid_vld || c2_ld[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_vld <= 1'b0;
    end else if (mid_ld) begin
      mid_vld <= c1_vld[N1];
    end
  end

  always_ff @(posedge clk) begin
    if (mid_ld) begin
      mid_n    <= {f, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, f};
      mid_sext <= h[SEXT_W-1:0];
      mid_err  <= h_err;
    end
  end

  // Ramp divide: the upper bits of 255 * f are already below the segment
  // length, so eight cells give the 8-bit ramp.
  assign c2_vld[0] = mid_vld;
  assign c2_rem[0] = mid_n[PRODW-1:LEVEL_W];
  assign c2_nq[0]  = mid_n[LEVEL_W-1:0];
  assign c2_tag[0] = {mid_err, mid_sext};
  assign c2_ld[N2] = out_ld;

  for (genvar k = 0; k < N2; k++) begin : g_c2
    hwr_div_cell #(.RW(SEG_W), .NW(N2), .TW(TAG2)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c2_vld[k]),
      .in_rem    (c2_rem[k]),
      .in_nq     (c2_nq[k]),
      .in_tag    (c2_tag[k]),
      .seg       (seg),
      .down_ld   (c2_ld[k+1]),
      .ld        (c2_ld[k]),
      .out_valid (c2_vld[k+1]),
      .out_rem   (c2_rem[k+1]),
      .out_nq    (c2_nq[k+1]),
      .out_tag   (c2_tag[k+1])
    );
  end

  // Color lookup into the output register.
  assign fin_sext = c2_tag[N2][SEXT_W-1:0];
  assign fin_err  = c2_tag[N2][SEXT_W];
  assign color    = hwr_color(fin_sext, fin_err, c2_nq[N2]);
  assign out_ld   = !rgb_out.valid || rgb_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_out.valid <= 1'b0;
    end else if (out_ld) begin
      rgb_out.valid <= c2_vld[N2];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      rgb_out.red          <= color.red;
      rgb_out.green        <= color.green;
      rgb_out.blue         <= color.blue;
      rgb_out.out_of_range <= fin_err;
    end
  end

endmodule

### rtl/hwr_checker.sv
// ----------------------------------------------------------------------------
// hwr_checker: port-level checks for the hue wheel to RGB block
// Watches the result channel and the configuration port over time.
// ----------------------------------------------------------------------------
module hwr_checker import hwr_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [LEVEL_W-1:0]    red,
  input logic [LEVEL_W-1:0]    green,
  input logic [LEVEL_W-1:0]    blue,
  input logic                  out_of_range,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [APB_ADDR_W-1:0] paddr,
  input logic [APB_DATA_W-1:0] pwdata,
  input logic [APB_DATA_W-1:0] prdata
);

  // An error result is always black.
  a_err_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> red == '0 && green == '0 && blue == '0)
    else $error("out_of_range result is not black");

  // A valid color has one channel at full level and one at zero.
  a_saturated: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_range |->
      (red == FULL_LEVEL || green == FULL_LEVEL || blue == FULL_LEVEL) &&
      (red == '0 || green == '0 || blue == '0))
    else $error("color is not fully saturated");

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) &&
      $stable(blue) && $stable(out_of_range))
    else $error("stalled result changed");

  // A period write reads back on the next cycle.
  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr == REG_HUE_PERIOD
      ##1 paddr == REG_HUE_PERIOD |->
      prdata == {{(APB_DATA_W-HUE_W){1'b0}}, $past(pwdata[HUE_W-1:0])})
    else $error("period register read back mismatch");

endmodule

bind hue_wheel_to_rgb hwr_checker u_hwr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (rgb_out.valid),
  .out_ready    (rgb_out.ready),
  .red          (rgb_out.red),
  .green        (rgb_out.green),
  .blue         (rgb_out.blue),
  .out_of_range (rgb_out.out_of_range),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata)
);
